[rtl/alir_pkg.sv]
// Shared types and constants for the array list block.
// Used by alir_cell, alir_find and array_list_insert_remove; no dependencies.
package alir_pkg;

	localparam int DEF_CAPACITY = 64;
	localparam int WORD_W = 32;

	typedef enum logic [1:0] {
		KIND_APPEND       = 2'd0,
		KIND_INSERT       = 2'd1,
		KIND_REMOVE_AT    = 2'd2,
		KIND_REMOVE_VALUE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REMOVE
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	// Broadcast from the control to every cell of the row.
	typedef struct packed {
		cell_op_t            op;
		logic [WORD_W-1:0]   word;
	} cell_ctrl_t;

endpackage

[rtl/alir_cell.sv]
// One storage cell of the list row: holds one entry, moves it to or from its neighbors.
// Depends on alir_pkg.
module alir_cell import alir_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int IDX = 0,
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [IDX_W-1:0]  pos,
	input  logic [CNT_W-1:0]  count,
	input  logic [WORD_W-1:0] left_word,
	input  logic [WORD_W-1:0] right_word,
	output logic [WORD_W-1:0] entry,
	output logic              match
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [WORD_W-1:0] entry_q;

	assign entry = entry_q;
	// Only live entries take part in a search.
	assign match = (entry_q == ctrl.word) && (CNT_W'(IDX) < count);

	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_INSERT: begin
				if (MY_IDX > pos) begin
					entry_q <= left_word;
				end else if (MY_IDX == pos) begin
					entry_q <= ctrl.word;
				end
			end
			CELL_REMOVE: begin
				if (MY_IDX >= pos) begin
					entry_q <= right_word;
				end
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

[rtl/alir_find.sv]
// Registered find-first tree over the cell match flags: every tree level, leaves included, is a register.
// Depends on alir_pkg.
module alir_find import alir_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int LEAVES = 1 << IDX_W
) (
	input  logic                clk,
	input  logic [CAPACITY-1:0] match,
	output logic                hit,
	output logic [IDX_W-1:0]    index
);

	// Heap layout: node 1 is the root, leaves sit at LEAVES .. 2*LEAVES-1.
	logic             hit_q [1:2*LEAVES-1];
	logic [IDX_W-1:0] idx_q [1:2*LEAVES-1];

	genvar j;
	generate
		for (j = LEAVES; j < 2 * LEAVES; j++) begin : g_leaf
			localparam int LEAF = j - LEAVES;
			if (LEAF < CAPACITY) begin : g_live
				always_ff @(posedge clk) begin
					hit_q[j] <= match[LEAF];
				end
			end else begin : g_pad
				always_ff @(posedge clk) begin
					hit_q[j] <= 1'b0;
				end
			end
			always_ff @(posedge clk) begin
				idx_q[j] <= IDX_W'(LEAF);
			end
		end
		for (j = 1; j < LEAVES; j++) begin : g_node
			// Prefer the left child: it holds the lower positions.
			always_ff @(posedge clk) begin
				hit_q[j] <= hit_q[2*j] | hit_q[2*j+1];
				idx_q[j] <= hit_q[2*j] ? idx_q[2*j] : idx_q[2*j+1];
			end
		end
	endgenerate

	assign hit = hit_q[1];
	assign index = idx_q[1];

endmodule

[rtl/array_list_insert_remove.sv]
// Top level of the array list block: control, result register, row of cells, find tree.
// Depends on alir_pkg, alir_cell and alir_find.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per item: kind, position,
//   value. Output channel (out_valid/out_ready) returns one result per item: ok,
//   count_after, removed_word, found_position.
//   Append, insert and remove-at finish in the cycle they are accepted; the result
//   appears on the output register in the next cycle. Throughput is one item per cycle
//   while the receiver keeps up.
//   Remove-value first compares every cell against the word, then walks the match
//   flags through a registered find-first tree of log2(CAPACITY) levels. The item
//   occupies the block until the search has walked the depth of that tree; the
//   removal is applied on the final cycle of the search.
//   A new item is taken only when the block is idle and the output register is free
//   or being emptied in the same cycle, so a stalled receiver holds the block.
//   Reset clears the count, the control state and the output valid flag; entries
//   are left as they are and are only read below the count.
module array_list_insert_remove import alir_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	localparam int IDX_W = $clog2(CAPACITY),
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [5:0]         position,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               ok,
	output logic [6:0]         count_after,
	output logic signed [31:0] removed_word,
	output logic [5:0]         found_position
);

	localparam int LEVELS = IDX_W;
	localparam int SRCH_W = $clog2(LEVELS + 2);
	localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [SRCH_W-1:0] SRCH_LAST = SRCH_W'(LEVELS + 1);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [SRCH_W-1:0]  srch_q;
	logic [WORD_W-1:0]  word_q;

	logic               out_valid_q;
	logic               ok_q;
	logic [6:0]         count_after_q;
	logic [WORD_W-1:0]  removed_q;
	logic [5:0]         found_q;

	logic               in_fire;
	logic               emit;
	logic               res_ok;
	logic [CNT_W-1:0]   res_count;
	logic [WORD_W-1:0]  res_removed;
	logic [5:0]         res_found;
	cell_ctrl_t         ctrl;
	logic [IDX_W-1:0]   ctrl_pos;

	logic [CMP_W-1:0]   pos_w;
	logic [CMP_W-1:0]   count_w;
	logic               has_room;

	logic [WORD_W-1:0]  ent [0:CAPACITY-1];
	logic [CAPACITY-1:0] match;
	logic               find_hit;
	logic [IDX_W-1:0]   find_idx;

	// Take an item only when idle and the result slot frees up this cycle.
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire = in_valid && in_ready;

	assign pos_w = CMP_W'(position);
	assign count_w = CMP_W'(count_q);
	assign has_room = count_q < CAP_CNT;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && (kind_t'(kind) == KIND_REMOVE_VALUE)) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (srch_q == SRCH_LAST) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Cell commands and result fields.
	always_comb begin
		emit = 1'b0;
		res_ok = 1'b0;
		res_count = count_q;
		res_removed = '0;
		res_found = '0;
		ctrl.op = CELL_HOLD;
		ctrl.word = word_q;
		ctrl_pos = '0;
		case (state_q)
			ST_IDLE: begin
				ctrl.word = value;
				if (in_fire) begin
					case (kind_t'(kind))
						KIND_APPEND: begin
							emit = 1'b1;
							if (has_room) begin
								// Append is an insert at the end of the list.
								res_ok = 1'b1;
								res_count = count_q + 1'b1;
								ctrl.op = CELL_INSERT;
								ctrl_pos = IDX_W'(count_q);
							end
						end
						KIND_INSERT: begin
							emit = 1'b1;
							if (has_room && (pos_w <= count_w)) begin
								res_ok = 1'b1;
								res_count = count_q + 1'b1;
								ctrl.op = CELL_INSERT;
								ctrl_pos = IDX_W'(position);
							end
						end
						KIND_REMOVE_AT: begin
							emit = 1'b1;
							if (pos_w < count_w) begin
								res_ok = 1'b1;
								res_count = count_q - 1'b1;
								res_removed = ent[IDX_W'(position)];
								ctrl.op = CELL_REMOVE;
								ctrl_pos = IDX_W'(position);
							end
						end
						default: begin
							// Remove-value: latch the word and start the search.
							emit = 1'b0;
						end
					endcase
				end
			end
			ST_SEARCH: begin
				if (srch_q == SRCH_LAST) begin
					emit = 1'b1;
					if (find_hit) begin
						// The removed entry equals the searched word.
						res_ok = 1'b1;
						res_count = count_q - 1'b1;
						res_removed = word_q;
						res_found = 6'(find_idx);
						ctrl.op = CELL_REMOVE;
						ctrl_pos = find_idx;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			srch_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= res_count;
			if (state_q == ST_SEARCH) begin
				srch_q <= srch_q + 1'b1;
			end else begin
				srch_q <= '0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload and search word; no reset needed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			word_q <= value;
		end
		if (emit) begin
			ok_q <= res_ok;
			count_after_q <= 7'(res_count);
			removed_q <= res_removed;
			found_q <= res_found;
		end
	end

	assign out_valid = out_valid_q;
	assign ok = ok_q;
	assign count_after = count_after_q;
	assign removed_word = removed_q;
	assign found_position = found_q;

	// Row of cells: each one shifts to or from its neighbor on insert and remove.
	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic [WORD_W-1:0] left_w;
			logic [WORD_W-1:0] right_w;
			if (i == 0) begin : g_first
				assign left_w = ctrl.word;
			end else begin : g_mid_l
				assign left_w = ent[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_w = ent[i];
			end else begin : g_mid_r
				assign right_w = ent[i+1];
			end
			alir_cell #(
				.CAPACITY(CAPACITY),
				.IDX(i)
			) u_cell (
				.clk(clk),
				.ctrl(ctrl),
				.pos(ctrl_pos),
				.count(count_q),
				.left_word(left_w),
				.right_word(right_w),
				.entry(ent[i]),
				.match(match[i])
			);
		end
	endgenerate

	alir_find #(
		.CAPACITY(CAPACITY)
	) u_find (
		.clk(clk),
		.match(match),
		.hit(find_hit),
		.index(find_idx)
	);

endmodule
